// ===== rtl/mmss_pkg.sv =====
// ----------------------------------------------------------------------------
// mmss_pkg - shared types, constants and arithmetic helpers
// Digit positions, segment encodings and the constant-divisor helpers used by
// the minutes:seconds seven-segment scan.
// ----------------------------------------------------------------------------
`default_nettype none

package mmss_pkg;

    // Field widths
    localparam int unsigned COUNT_W   = 15;
    localparam int unsigned MINUTES_W = 10;
    localparam int unsigned SEG_W     = 7;
    localparam int unsigned DIGITS    = 4;
    localparam int unsigned POS_W     = 2;

    // Constant divisors and their reciprocals
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned DIGIT_BASE   = 10;
    // ceil(2^21 / 60): exact quotient for every 15-bit count
    localparam int unsigned DIV60_RECIP  = 34953;
    localparam int unsigned DIV60_SHIFT  = 21;
    // ceil(2^11 / 10): exact quotient for every value below 1024
    localparam int unsigned DIV10_RECIP  = 205;
    localparam int unsigned DIV10_SHIFT  = 11;

    // Active-low segment pattern with every segment dark
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

    // Scan order of the four digits
    typedef enum logic [POS_W-1:0] {
        POS_MIN_TENS  = 2'd0,
        POS_MIN_UNITS = 2'd1,
        POS_SEC_TENS  = 2'd2,
        POS_SEC_UNITS = 2'd3
    } t_digit_pos;

    // Count of seconds to whole minutes
    function automatic logic [MINUTES_W-1:0] div60(input logic [COUNT_W-1:0] v);
        logic [30:0] prod;
        prod = 31'(v) * 31'(DIV60_RECIP);
        return prod[DIV60_SHIFT +: MINUTES_W];
    endfunction

    // Quotient by ten for values below 1024
    function automatic logic [6:0] div10(input logic [MINUTES_W-1:0] v);
        logic [17:0] prod;
        prod = 18'(v) * 18'(DIV10_RECIP);
        return prod[DIV10_SHIFT +: 7];
    endfunction

    // Remainder by ten for values below 1024
    function automatic logic [3:0] mod10(input logic [MINUTES_W-1:0] v);
        logic [6:0]           quo;
        logic [MINUTES_W-1:0] diff;
        quo  = div10(v);
        diff = v - (MINUTES_W'(quo) * MINUTES_W'(DIGIT_BASE));
        return diff[3:0];
    endfunction

    // Digit to active-low segments, bit0 = a through bit6 = g
    function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] d);
        logic [SEG_W-1:0] seg;
        case (d)
            4'd0:    seg = 7'h40;
            4'd1:    seg = 7'h79;
            4'd2:    seg = 7'h24;
            4'd3:    seg = 7'h30;
            4'd4:    seg = 7'h19;
            4'd5:    seg = 7'h12;
            4'd6:    seg = 7'h02;
            4'd7:    seg = 7'h78;
            4'd8:    seg = 7'h00;
            4'd9:    seg = 7'h10;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mmss_if.sv =====
// ----------------------------------------------------------------------------
// mmss_if - request channels of the seven-segment scan
// Valid/ready channels for the seconds count coming in and the digit drive
// going out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmss_in_if;
    logic                             valid;
    logic                             ready;
    logic [mmss_pkg::COUNT_W-1:0]     total_seconds;

    modport source (output valid, output total_seconds, input ready);
    modport sink   (input valid, input total_seconds, output ready);
endinterface

interface mmss_out_if;
    logic                             valid;
    logic                             ready;
    logic [mmss_pkg::SEG_W-1:0]       segments_n;
    logic [mmss_pkg::DIGITS-1:0]      digit_enable_n;
    logic                             colon_n;
    logic [mmss_pkg::POS_W-1:0]       digit_position;

    modport source (output valid, output segments_n, output digit_enable_n,
                    output colon_n, output digit_position, input ready);
    modport sink   (input valid, input segments_n, input digit_enable_n,
                    input colon_n, input digit_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/mmss_seven_segment_scan.sv =====
// ----------------------------------------------------------------------------
// mmss_seven_segment_scan - multiplexed minutes:seconds display scan
// Each request carries a seconds count; the block drives one of four digits
// (minute tens, minute units, second tens, second units) in rotation.
// ----------------------------------------------------------------------------
// Throughput is one request per clock unless the output stalls: the count
// lands in an input register, the digit split (reciprocal multiply by 1/60,
// then by 1/10), segment decode and enable generation run in one pass, and
// the drive lands in the output register. The scan position steps once per
// request from minute tens to second units and wraps; minute tens is taken
// mod 10, so the display rolls over past 99 minutes. A stalled output does
// not block intake until the input register is also holding a request.
`default_nettype none

module mmss_seven_segment_scan (
    input  wire               i_clk,
    input  wire               i_rst_n,
    mmss_in_if.sink           i_in,
    mmss_out_if.source        o_out
);

    // Input stage
    logic                               r_s1_valid;
    logic [mmss_pkg::COUNT_W-1:0]       r_s1_count;
    mmss_pkg::t_digit_pos               r_scan;

    // Output stage
    logic                               r_out_valid;
    logic [mmss_pkg::SEG_W-1:0]         r_segments_n;
    logic [mmss_pkg::DIGITS-1:0]        r_digit_enable_n;
    logic                               r_colon_n;
    logic [mmss_pkg::POS_W-1:0]         r_digit_position;

    // Next values
    logic                               out_free;
    logic                               s1_move;
    logic [mmss_pkg::MINUTES_W-1:0]     minutes;
    logic [mmss_pkg::COUNT_W-1:0]       seconds_wide;
    logic [mmss_pkg::MINUTES_W-1:0]     seconds;
    logic [3:0]                         digit;
    logic [mmss_pkg::SEG_W-1:0]         n_segments_n;
    logic [mmss_pkg::DIGITS-1:0]        n_digit_enable_n;
    logic                               n_colon_n;
    mmss_pkg::t_digit_pos               n_scan;

    // Handshake: the input stage moves when the output register is free
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    // Split the count into minutes and seconds
    assign minutes      = mmss_pkg::div60(r_s1_count);
    assign seconds_wide = r_s1_count -
                          (mmss_pkg::COUNT_W'(minutes) *
                           mmss_pkg::COUNT_W'(mmss_pkg::SECS_PER_MIN));
    assign seconds      = seconds_wide[mmss_pkg::MINUTES_W-1:0];

    // Pick the digit under the scan position
    always_comb begin
        unique case (r_scan)
            mmss_pkg::POS_MIN_TENS:
                digit = mmss_pkg::mod10(mmss_pkg::MINUTES_W'(mmss_pkg::div10(minutes)));
            mmss_pkg::POS_MIN_UNITS:
                digit = mmss_pkg::mod10(minutes);
            mmss_pkg::POS_SEC_TENS:
                digit = mmss_pkg::mod10(mmss_pkg::MINUTES_W'(mmss_pkg::div10(seconds)));
            mmss_pkg::POS_SEC_UNITS:
                digit = mmss_pkg::mod10(seconds);
            default:
                digit = 4'd0;
        endcase
    end

    // Decode segments, enable and colon
    assign n_segments_n     = mmss_pkg::seg_decode(digit);
    assign n_digit_enable_n = ~(mmss_pkg::DIGITS'(1) << r_scan);
    assign n_colon_n        = (r_scan != mmss_pkg::POS_MIN_UNITS);
    assign n_scan           = mmss_pkg::t_digit_pos'(r_scan + mmss_pkg::POS_W'(1));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= mmss_pkg::POS_MIN_TENS;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            // Advance the scan once per request processed
            if (s1_move) begin
                r_scan <= n_scan;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_count <= i_in.total_seconds;
        end
        if (s1_move) begin
            r_segments_n     <= n_segments_n;
            r_digit_enable_n <= n_digit_enable_n;
            r_colon_n        <= n_colon_n;
            r_digit_position <= r_scan;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.segments_n     = r_segments_n;
    assign o_out.digit_enable_n = r_digit_enable_n;
    assign o_out.colon_n        = r_colon_n;
    assign o_out.digit_position = r_digit_position;

    // Exactly one digit enabled, and it matches the reported position
    a_enable_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($onehot(~r_digit_enable_n) &&
                         r_digit_enable_n[r_digit_position] == 1'b0))
        else $error("digit enable does not match digit position");

    // Colon lit on the minute units digit only
    a_colon_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_colon_n == (r_digit_position != mmss_pkg::POS_MIN_UNITS)))
        else $error("colon driven on wrong digit");

    // Scan steps by one for each request processed, holds otherwise
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> (r_scan == mmss_pkg::t_digit_pos'($past(r_scan) + mmss_pkg::POS_W'(1))))
        else $error("scan position did not advance");

    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_move |=> $stable(r_scan))
        else $error("scan position moved without a request");

    // A held input request is not overwritten while the output stalls
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_count)))
        else $error("input stage lost a request");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - minutes:seconds seven-segment scan
// Drives seconds-count requests through the input channel and checks every
// digit drive on the output channel against a scoreboard of predicted drives.
// The stimulus starts with a short table of fixed cases, then moves to random
// counts that lean toward minute, ten-minute and hundred-minute boundaries.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;

    localparam int unsigned CLK_PERIOD_NS   = 12;
    localparam int unsigned RESET_CYCLES    = 5;
    localparam int unsigned RANDOM_REQUESTS = 450;
    localparam int unsigned MAX_WAIT        = 11;
    localparam int unsigned BURST_SPAN      = 40;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned NUM_DIRECTED    = 24;
    localparam int unsigned MAX_COUNT       = (1 << mmss_pkg::COUNT_W) - 1;
    // First count that shows more than 99 minutes
    localparam int unsigned WRAP_COUNT      = 6000;

    // One digit drive as it appears on the output channel
    typedef struct packed {
        logic [mmss_pkg::SEG_W-1:0]  segments_n;
        logic [mmss_pkg::DIGITS-1:0] digit_enable_n;
        logic                        colon_n;
        mmss_pkg::t_digit_pos        digit_position;
    } t_digit_drive;

    // One row of the directed table; typed rows carry their drive
    typedef struct {
        logic [mmss_pkg::COUNT_W-1:0] count;
        bit                           typed;
        t_digit_drive                 drive;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    mmss_in_if  in_ch ();
    mmss_out_if out_ch ();

    mmss_seven_segment_scan dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Active-low glyphs for the digits 0 through 9
    logic [mmss_pkg::SEG_W-1:0] glyph_rom [0:9] = '{
        7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
        7'h12, 7'h02, 7'h78, 7'h00, 7'h10
    };

    // Fixed cases: all-zero and full-scale counts on every position, then
    // the 99:59 / 100:00 rollover, minute edges and alternating bit patterns
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{15'd0,     1'b1, '{7'h40, 4'b1110, 1'b1, mmss_pkg::POS_MIN_TENS}},
        '{15'd0,     1'b1, '{7'h40, 4'b1101, 1'b0, mmss_pkg::POS_MIN_UNITS}},
        '{15'd0,     1'b1, '{7'h40, 4'b1011, 1'b1, mmss_pkg::POS_SEC_TENS}},
        '{15'd0,     1'b1, '{7'h40, 4'b0111, 1'b1, mmss_pkg::POS_SEC_UNITS}},
        '{15'd32767, 1'b1, '{7'h19, 4'b1110, 1'b1, mmss_pkg::POS_MIN_TENS}},
        '{15'd32767, 1'b1, '{7'h02, 4'b1101, 1'b0, mmss_pkg::POS_MIN_UNITS}},
        '{15'd32767, 1'b1, '{7'h40, 4'b1011, 1'b1, mmss_pkg::POS_SEC_TENS}},
        '{15'd32767, 1'b1, '{7'h78, 4'b0111, 1'b1, mmss_pkg::POS_SEC_UNITS}},
        '{15'd5999,  1'b0, '0},
        '{15'd6000,  1'b0, '0},
        '{15'd5999,  1'b0, '0},
        '{15'd5999,  1'b0, '0},
        '{15'd6000,  1'b0, '0},
        '{15'd3599,  1'b0, '0},
        '{15'd59,    1'b0, '0},
        '{15'd60,    1'b0, '0},
        '{15'd21845, 1'b0, '0},
        '{15'd10922, 1'b0, '0},
        '{15'd599,   1'b0, '0},
        '{15'd600,   1'b0, '0},
        '{15'd3600,  1'b0, '0},
        '{15'd1234,  1'b0, '0},
        '{15'd4321,  1'b0, '0},
        '{15'd2468,  1'b0, '0}
    };

    t_digit_drive         pending_drives [$];
    mmss_pkg::t_digit_pos scan_pos;
    int unsigned          requests_sent;
    int unsigned          wrapped_requests;
    int unsigned          drives_checked;
    int unsigned          error_count;
    int unsigned          cycle_count;
    int unsigned          drives_per_pos [mmss_pkg::DIGITS];
    bit                   src_burst;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2.0) i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles, %0d drives still pending",
                     $time, CYCLE_LIMIT, pending_drives.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Digit drive for one count at one scan position
    function automatic t_digit_drive predict_digit_drive(
        input logic [mmss_pkg::COUNT_W-1:0] count,
        input mmss_pkg::t_digit_pos         pos
    );
        int unsigned  minutes;
        int unsigned  seconds;
        int unsigned  digit;
        t_digit_drive drive;
        minutes = count / mmss_pkg::SECS_PER_MIN;
        seconds = count % mmss_pkg::SECS_PER_MIN;
        case (pos)
            mmss_pkg::POS_MIN_TENS:
                digit = (minutes / mmss_pkg::DIGIT_BASE) % mmss_pkg::DIGIT_BASE;
            mmss_pkg::POS_MIN_UNITS:
                digit = minutes % mmss_pkg::DIGIT_BASE;
            mmss_pkg::POS_SEC_TENS:
                digit = (seconds / mmss_pkg::DIGIT_BASE) % mmss_pkg::DIGIT_BASE;
            default:
                digit = seconds % mmss_pkg::DIGIT_BASE;
        endcase
        drive.segments_n     = (digit >= mmss_pkg::DIGIT_BASE) ? mmss_pkg::SEG_BLANK
                                                               : glyph_rom[digit];
        drive.digit_enable_n = ~(mmss_pkg::DIGITS'(1) << pos);
        drive.colon_n        = (pos != mmss_pkg::POS_MIN_UNITS);
        drive.digit_position = pos;
        return drive;
    endfunction

    // Idle cycles before the next request or result; whole spans run without
    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_field(input string name, input int unsigned expv,
                                input int unsigned actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch on drive %0d: expected 0x%0h, actual 0x%0h",
                     $time, name, drives_checked, expv, actv);
            error_count++;
        end
    endtask

    // Send one request and queue its predicted drive once accepted
    task automatic send_request(input logic [mmss_pkg::COUNT_W-1:0] count,
                                input bit typed, input t_digit_drive typed_drive);
        int unsigned gap;
        if (requests_sent % BURST_SPAN == 0)
            src_burst = ($urandom_range(0, 2) == 0);
        gap = draw_wait(src_burst);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.total_seconds <= count;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_drives.push_back(typed ? typed_drive : predict_digit_drive(count, scan_pos));
        scan_pos = mmss_pkg::t_digit_pos'(scan_pos + 1'b1);
        requests_sent++;
        if (count >= WRAP_COUNT)
            wrapped_requests++;
    endtask

    // Random count, biased toward the edges where digits roll over
    function automatic logic [mmss_pkg::COUNT_W-1:0] pick_count();
        int v;
        case ($urandom_range(0, 9))
            6:       v = mmss_pkg::SECS_PER_MIN
                         * $urandom_range(1, MAX_COUNT / mmss_pkg::SECS_PER_MIN)
                         + $urandom_range(0, 2) - 1;
            7:       v = 600 * $urandom_range(1, MAX_COUNT / 600) + $urandom_range(0, 2) - 1;
            8:       v = WRAP_COUNT * $urandom_range(1, MAX_COUNT / WRAP_COUNT)
                         + $urandom_range(0, 2) - 1;
            9:       v = $urandom_range(0, 599);
            default: v = $urandom_range(0, MAX_COUNT);
        endcase
        if (v > int'(MAX_COUNT))
            v = MAX_COUNT;
        return mmss_pkg::COUNT_W'(v);
    endfunction

    // Result side: stall at random, with spans of constant ready
    initial begin
        int unsigned results_seen;
        int unsigned stall;
        bit          snk_burst;
        results_seen = 0;
        snk_burst    = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (results_seen % BURST_SPAN == 0)
                snk_burst = ($urandom_range(0, 2) == 0);
            stall = draw_wait(snk_burst);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            results_seen++;
        end
    end

    // Check each accepted drive against the oldest prediction
    always @(posedge i_clk) begin
        t_digit_drive want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_drives.size() == 0) begin
                $display("%0t: unexpected drive: expected none, actual seg 0x%0h en 0x%0h",
                         $time, out_ch.segments_n, out_ch.digit_enable_n);
                error_count++;
            end else begin
                want = pending_drives.pop_front();
                report_field("segments_n", want.segments_n, out_ch.segments_n);
                report_field("digit_enable_n", want.digit_enable_n, out_ch.digit_enable_n);
                report_field("colon_n", want.colon_n, out_ch.colon_n);
                report_field("digit_position", want.digit_position, out_ch.digit_position);
                drives_per_pos[want.digit_position]++;
            end
            drives_checked++;
        end
    end

    // Reset, stimulus, drain and verdict
    initial begin
        scan_pos         = mmss_pkg::POS_MIN_TENS;
        requests_sent    = 0;
        wrapped_requests = 0;
        drives_checked   = 0;
        error_count      = 0;
        cycle_count      = 0;
        src_burst        = 1'b0;
        foreach (drives_per_pos[i])
            drives_per_pos[i] = 0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.total_seconds <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].count, directed_rows[i].typed,
                         directed_rows[i].drive);
        repeat (RANDOM_REQUESTS)
            send_request(pick_count(), 1'b0, '0);
        in_ch.valid <= 1'b0;

        // Wait for every drive, then watch for strays
        while (pending_drives.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d seconds counts (%0d beyond 99 minutes), checked %0d drives",
                 requests_sent, wrapped_requests, drives_checked);
        $display("Drives per digit: min tens %0d, min units %0d, sec tens %0d, sec units %0d",
                 drives_per_pos[0], drives_per_pos[1], drives_per_pos[2], drives_per_pos[3]);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
